/* rtl/packet_header_parser_macros.svh */
// Assertion helpers for the packet header parser.
// Both forms are clocked on aclk and are switched off while aresetn is low.
`ifndef PACKET_HEADER_PARSER_MACROS_SVH
`define PACKET_HEADER_PARSER_MACROS_SVH

// Same-cycle implication.
`define PHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PHP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/php_pkg.sv */
package php_pkg;

    localparam int unsigned MAX_FRAME_DEF = 2048;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] FK_IPV4  = 2'd0;
    localparam logic [1:0] FK_ARP   = 2'd1;
    localparam logic [1:0] FK_OTHER = 2'd2;

    localparam logic [2:0] TK_NONE  = 3'd0;
    localparam logic [2:0] TK_ICMP  = 3'd1;
    localparam logic [2:0] TK_TCP   = 3'd2;
    localparam logic [2:0] TK_UDP   = 3'd3;
    localparam logic [2:0] TK_OTHER = 3'd4;

    localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
    localparam logic [15:0] ARP_BODY_BYTES = 16'd28;
    localparam logic [5:0]  MIN_IP_HDR = 6'd20;
    localparam logic [15:0] PORT_HDR_BYTES = 16'd8;
    localparam logic [15:0] MIN_TCP_HDR = 16'd20;

    // Frame state captured at the last byte of a frame.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] ether_kind;
        logic [5:0]  header_len;
        logic [15:0] tcp_len;
        logic [7:0]  proto;
        logic [15:0] ip_accum;
        logic [15:0] tcp_accum;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_offset_byte;
        logic [7:0]  tcp_flags;
        logic [15:0] arp_op;
        logic [3:0]  ip_version;
    } snap_t;

    // Summary transaction; the first member sits in the highest bits.
    typedef struct packed {
        logic        truncated;
        logic [15:0] op_code;
        logic [5:0]  tcp_offset_bytes;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic        tcp_sum_ok;
        logic        ip_sum_ok;
        logic [5:0]  ip_header_bytes;
        logic [3:0]  ip_version;
        logic [2:0]  transport_kind;
        logic [1:0]  frame_kind;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

    // Ones'-complement add with end-around carry.
    function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    function automatic logic [5:0] transport_start(input logic [5:0] hlen);
        return (hlen < MIN_IP_HDR) ? MIN_IP_HDR : hlen;
    endfunction

endpackage

/* rtl/php_parse.sv */
module php_parse #(
    parameter int unsigned MAX_FRAME = php_pkg::MAX_FRAME_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           byte_go,
    input  logic [7:0]     frame_byte,
    input  logic           frame_end,
    output php_pkg::snap_t snap_next
);
    import php_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_FRAME + 1);

    logic [IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic [15:0] ether_reg, ether_next;
    logic [5:0]  hlen_reg, hlen_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] ip_acc_reg, ip_acc_next;
    logic [15:0] tcp_acc_reg, tcp_acc_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [7:0]  b12_reg, b12_next;
    logic [7:0]  b13_reg, b13_next;
    logic [15:0] arp_op_reg, arp_op_next;
    logic [3:0]  ver_reg, ver_next;

    logic [15:0] idx16, k, t, word, tlen, start16;
    logic [16:0] t_plus1;
    logic [5:0]  start;

    always_comb begin
        byte_idx_next = byte_idx_reg;
        ether_next    = ether_reg;
        hlen_next     = hlen_reg;
        total_next    = total_reg;
        proto_next    = proto_reg;
        ip_acc_next   = ip_acc_reg;
        tcp_acc_next  = tcp_acc_reg;
        hold_next     = hold_reg;
        sport_next    = sport_reg;
        dport_next    = dport_reg;
        b12_next      = b12_reg;
        b13_next      = b13_reg;
        arp_op_next   = arp_op_reg;
        ver_next      = ver_reg;

        idx16   = 16'(byte_idx_reg);
        k       = idx16 - ETH_HDR_BYTES;
        word    = {hold_reg, frame_byte};
        start   = transport_start(hlen_reg);
        start16 = {10'b0, start};
        tlen    = total_reg - start16;
        t       = k - start16;
        t_plus1 = {1'b0, t} + 17'd1;

        if (byte_idx_reg < IDX_W'(MAX_FRAME)) begin
            byte_idx_next = byte_idx_reg + IDX_W'(1);
            if (idx16 == 16'd12) begin
                hold_next = frame_byte;
            end else if (idx16 == 16'd13) begin
                ether_next = word;
            end else if (idx16 > 16'd13) begin
                if (ether_reg == ETH_TYPE_ARP) begin
                    if (k == 16'd6) hold_next = frame_byte;
                    if (k == 16'd7) arp_op_next = word;
                end else if (ether_reg == ETH_TYPE_IPV4) begin
                    if (k == 16'd0) begin
                        ver_next  = frame_byte[7:4];
                        hlen_next = {frame_byte[3:0], 2'b00};
                    end
                    if (k == 16'd3) total_next = word;
                    if (k == 16'd9) proto_next = frame_byte;
                    if (k[0]) begin
                        if (k < {10'b0, hlen_reg}) ip_acc_next = fold_add(ip_acc_reg, word);
                        if (k >= 16'd12 && k <= 16'd19) begin
                            tcp_acc_next = fold_add(tcp_acc_reg, word);
                        end
                    end
                    if (k >= start16) begin
                        if (t == 16'd1)  sport_next = word;
                        if (t == 16'd3)  dport_next = word;
                        if (t == 16'd12) b12_next = frame_byte;
                        if (t == 16'd13) b13_next = frame_byte;
                        if (t < tlen) begin
                            if (t[0]) begin
                                tcp_acc_next = fold_add(tcp_acc_reg, word);
                            end else if (t_plus1 == {1'b0, tlen}) begin
                                tcp_acc_next = fold_add(tcp_acc_reg, {frame_byte, 8'h00});
                            end
                        end
                    end
                    if (!k[0]) hold_next = frame_byte;
                end
            end
        end

        snap_next.byte_count      = 16'(byte_idx_next);
        snap_next.ether_kind      = ether_next;
        snap_next.header_len      = hlen_next;
        snap_next.tcp_len         = total_next - {10'b0, transport_start(hlen_next)};
        snap_next.proto           = proto_next;
        snap_next.ip_accum        = ip_acc_next;
        snap_next.tcp_accum       = tcp_acc_next;
        snap_next.src_port        = sport_next;
        snap_next.dst_port        = dport_next;
        snap_next.tcp_offset_byte = b12_next;
        snap_next.tcp_flags       = b13_next;
        snap_next.arp_op          = arp_op_next;
        snap_next.ip_version      = ver_next;
    end

    // The frame state returns to zero after the last byte of each frame.
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_go && frame_end)) begin
            byte_idx_reg <= '0;
            ether_reg    <= '0;
            hlen_reg     <= '0;
            total_reg    <= '0;
            proto_reg    <= '0;
            ip_acc_reg   <= '0;
            tcp_acc_reg  <= '0;
            hold_reg     <= '0;
            sport_reg    <= '0;
            dport_reg    <= '0;
            b12_reg      <= '0;
            b13_reg      <= '0;
            arp_op_reg   <= '0;
            ver_reg      <= '0;
        end else if (byte_go) begin
            byte_idx_reg <= byte_idx_next;
            ether_reg    <= ether_next;
            hlen_reg     <= hlen_next;
            total_reg    <= total_next;
            proto_reg    <= proto_next;
            ip_acc_reg   <= ip_acc_next;
            tcp_acc_reg  <= tcp_acc_next;
            hold_reg     <= hold_next;
            sport_reg    <= sport_next;
            dport_reg    <= dport_next;
            b12_reg      <= b12_next;
            b13_reg      <= b13_next;
            arp_op_reg   <= arp_op_next;
            ver_reg      <= ver_next;
        end
    end

endmodule

/* rtl/php_summary.sv */
module php_summary (
    input  php_pkg::snap_t   snap,
    output php_pkg::result_t res
);
    import php_pkg::*;

    logic [5:0]  start;
    logic [15:0] extra;
    logic [16:0] need;
    logic        trunc;
    logic [15:0] tcp_fold, tcp_final;

    always_comb begin
        start = transport_start(snap.header_len);
        res   = '0;
        extra = '0;
        need  = {1'b0, ETH_HDR_BYTES};

        case (snap.ether_kind)
            ETH_TYPE_IPV4: begin
                res.frame_kind = FK_IPV4;
                case (snap.proto)
                    PROTO_ICMP: begin
                        res.transport_kind = TK_ICMP;
                        extra = PORT_HDR_BYTES;
                    end
                    PROTO_TCP: begin
                        res.transport_kind = TK_TCP;
                        extra = (snap.tcp_len < MIN_TCP_HDR) ? MIN_TCP_HDR : snap.tcp_len;
                    end
                    PROTO_UDP: begin
                        res.transport_kind = TK_UDP;
                        extra = PORT_HDR_BYTES;
                    end
                    default: begin
                        res.transport_kind = TK_OTHER;
                    end
                endcase
                need = {1'b0, ETH_HDR_BYTES} + {11'b0, start} + {1'b0, extra};
            end
            ETH_TYPE_ARP: begin
                res.frame_kind = FK_ARP;
                need = {1'b0, ETH_HDR_BYTES} + {1'b0, ARP_BODY_BYTES};
            end
            default: begin
                res.frame_kind = FK_OTHER;
            end
        endcase

        trunc         = {1'b0, snap.byte_count} < need;
        res.truncated = trunc;

        // Pseudo-header protocol and segment length close the TCP sum.
        tcp_fold  = fold_add(snap.tcp_accum, {8'b0, PROTO_TCP});
        tcp_final = fold_add(tcp_fold, snap.tcp_len);

        if (res.frame_kind == FK_IPV4) begin
            res.ip_version      = snap.ip_version;
            res.ip_header_bytes = snap.header_len;
            res.ip_sum_ok       = !trunc && (snap.ip_accum == 16'hFFFF);
            if (res.transport_kind == TK_TCP || res.transport_kind == TK_UDP) begin
                res.source_port = snap.src_port;
                res.dest_port   = snap.dst_port;
            end
            if (res.transport_kind == TK_TCP) begin
                res.tcp_sum_ok       = !trunc && (tcp_final == 16'hFFFF);
                res.tcp_flag_bits    = snap.tcp_flags;
                res.tcp_offset_bytes = {snap.tcp_offset_byte[7:4], 2'b00};
            end
            if (res.transport_kind == TK_ICMP) begin
                res.op_code = {8'b0, snap.src_port[15:8]};
            end
        end else if (res.frame_kind == FK_ARP) begin
            res.op_code = snap.arp_op;
        end
    end

endmodule

/* rtl/packet_header_parser.sv */
// The summary transaction moves to m_axis from the edge that accepts the last byte of a frame
// through the input register, then the snapshot register, then the summary register.
// Throughput: one byte per cycle while a frame's last byte is not held back by a full output side.
// Reset (aresetn low, synchronous) empties all three stages and clears the frame state.
module packet_header_parser #(
    parameter int unsigned MAX_FRAME = php_pkg::MAX_FRAME_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] frame_byte
    input  logic                         s_axis_tlast,  // frame_end
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // From the lowest bit: frame_kind[1:0], transport_kind[4:2], ip_version[8:5],
    // ip_header_bytes[14:9], ip_sum_ok[15], tcp_sum_ok[16], source_port[32:17],
    // dest_port[48:33], tcp_flag_bits[56:49], tcp_offset_bytes[62:57],
    // op_code[78:63], truncated[79].
    output logic [php_pkg::RESULT_W-1:0] m_axis_tdata
);
    import php_pkg::*;

    // Input stage: one byte of the frame, held until the parser takes it.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_last_reg, in_last_next;

    // Snapshot stage: the frame state as it stood after the last byte.
    logic  snap_valid_reg, snap_valid_next;
    snap_t snap_reg, snap_next_reg;
    snap_t snap_from_parse;

    // Output stage: the summary transaction offered on m_axis.
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    result_t summary;

    logic out_free, snap_free, proc_go, in_free;

    // Each stage frees up when it is empty or its contents move on this cycle.
    // Bytes that do not end a frame never wait on the output side, so the parser keeps
    // taking bytes while a finished summary is still waiting to be taken.
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign snap_free = !snap_valid_reg || out_free;
    assign proc_go   = in_valid_reg && (!in_last_reg || snap_free);
    assign in_free   = !in_valid_reg || proc_go;

    assign s_axis_tready = in_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    php_parse #(
        .MAX_FRAME(MAX_FRAME)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_go   (proc_go),
        .frame_byte(in_byte_reg),
        .frame_end (in_last_reg),
        .snap_next (snap_from_parse)
    );

    php_summary u_summary (
        .snap(snap_reg),
        .res (summary)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (in_free) begin
            in_valid_next = s_axis_tvalid;
            in_byte_next  = s_axis_tdata;
            in_last_next  = s_axis_tlast;
        end

        // A new snapshot replaces the old one only when the old one leaves in the same cycle.
        snap_valid_next = snap_valid_reg && !out_free;
        snap_next_reg   = snap_reg;
        if (proc_go && in_last_reg) begin
            snap_valid_next = 1'b1;
            snap_next_reg   = snap_from_parse;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free) begin
            out_valid_next = snap_valid_reg;
            out_next       = summary;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
        snap_reg    <= snap_next_reg;
        out_reg     <= out_next;
    end

`include "packet_header_parser_macros.svh"

    // Every frame end that the parser takes leaves a snapshot behind.
    `PHP_ASSERT_NXT(a_end_fills_snap, proc_go && in_last_reg, snap_valid_reg, "frame end lost")
    // A snapshot waiting on a stalled output stage is neither dropped nor overwritten.
    `PHP_ASSERT_NXT(a_snap_holds, snap_valid_reg && !out_free, snap_valid_reg && $stable(snap_reg), "pending snapshot disturbed")
    // A truncated frame never reports a good checksum.
    `PHP_ASSERT_IMP(a_trunc_no_sum, out_valid_reg && out_reg.truncated, !out_reg.ip_sum_ok && !out_reg.tcp_sum_ok, "checksum ok on truncated frame")
    // Only IPv4 frames carry a transport kind.
    `PHP_ASSERT_IMP(a_transport_ipv4, out_valid_reg && (out_reg.frame_kind != FK_IPV4), out_reg.transport_kind == TK_NONE, "transport kind on non-IPv4 frame")

endmodule

/* test/packet_header_parser_test.sv */
module packet_header_parser_test;
    import php_pkg::*;

    // Frame length limit of the parser under test; bytes beyond it are dropped.
    localparam int FRAME_CAP = MAX_FRAME_DEF;
    // Upper bound on the run.
    localparam int CYCLE_LIMIT = 1000000;

    // One byte of a frame as it travels on the input stream.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;  // [7:0] frame_byte
    logic                s_axis_tlast = 1'b0;   // frame_end
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // From the lowest bit: frame_kind, transport_kind, ip_version, ip_header_bytes,
    // ip_sum_ok, tcp_sum_ok, source_port, dest_port, tcp_flag_bits,
    // tcp_offset_bytes, op_code, truncated.
    logic [RESULT_W-1:0] m_axis_tdata;

    packet_header_parser uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // Frame under construction, the bytes waiting to be sent, and the summaries
    // that the accepted bytes call for, oldest first.
    logic [7:0] frm[$];
    beat_t      byte_q[$];
    result_t    summary_q[$];

    int total_bytes = 0;
    int bytes_taken = 0;
    int mismatches = 0;
    int cycles = 0;

    // Idle control. Each side runs in a busy stretch (a random idle gap before
    // each transaction) or a quiet stretch (no gaps) and switches now and then.
    bit src_busy = 1'b1;
    bit sink_busy = 1'b1;
    int src_gap = 0;
    int sink_gap = 0;

    beat_t   beat;
    result_t seen;
    result_t want;

    // Parser state as this bench tracks it, one copy for the frame in flight.
    int unsigned rx_count;
    logic [15:0] eth_type;
    logic [5:0]  ip_hlen;
    logic [15:0] ip_total;
    logic [7:0]  ip_proto;
    logic [15:0] ip_csum;
    logic [15:0] l4_csum;
    logic [7:0]  byte_hold;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  tcp_off_byte;
    logic [7:0]  tcp_flags;
    logic [15:0] arp_op;
    logic [3:0]  ip_ver;

    // Ones'-complement addition with the carry wrapped back into bit 0.
    function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic clear_parse_state();
        rx_count = 0;
        eth_type = '0;
        ip_hlen = '0;
        ip_total = '0;
        ip_proto = '0;
        ip_csum = '0;
        l4_csum = '0;
        byte_hold = '0;
        sport = '0;
        dport = '0;
        tcp_off_byte = '0;
        tcp_flags = '0;
        arp_op = '0;
        ip_ver = '0;
    endtask

    // The transport header starts at IP byte 20 even when IHL says less.
    function automatic int unsigned seg_start();
        return (ip_hlen < 20) ? 20 : ip_hlen;
    endfunction

    // Segment length that the TCP checksum covers; a total length below the
    // header size wraps to a huge value.
    function automatic logic [15:0] seg_len();
        logic [15:0] start16;
        start16 = 16'(seg_start());
        return ip_total - start16;
    endfunction

    // Advances the tracked parser state by one accepted byte. On the last byte of
    // a frame the expected summary is queued and the state starts over.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        int unsigned k;
        int unsigned start;
        int unsigned t;
        int unsigned tlen;
        int unsigned need;
        logic [15:0] word;
        logic [15:0] tcp_total;
        result_t r;

        if (rx_count < FRAME_CAP) begin
            if (rx_count == 12) begin
                byte_hold = b;
            end else if (rx_count == 13) begin
                eth_type = {byte_hold, b};
            end else if (rx_count > 13) begin
                k = rx_count - 14;
                if (eth_type == ETH_TYPE_ARP) begin
                    if (k == 6) byte_hold = b;
                    if (k == 7) arp_op = {byte_hold, b};
                end else if (eth_type == ETH_TYPE_IPV4) begin
                    word = {byte_hold, b};
                    if (k == 0) begin
                        ip_ver = b[7:4];
                        ip_hlen = {b[3:0], 2'b00};
                    end
                    if (k == 3) ip_total = word;
                    if (k == 9) ip_proto = b;
                    // Words are summed when their second byte arrives.
                    if (k[0]) begin
                        if (k < ip_hlen) ip_csum = csum_add(ip_csum, word);
                        // Source and destination addresses belong to the pseudo-header.
                        if (k >= 12 && k <= 19) l4_csum = csum_add(l4_csum, word);
                    end
                    start = seg_start();
                    if (k >= start) begin
                        t = k - start;
                        tlen = seg_len();
                        if (t == 1) sport = word;
                        if (t == 3) dport = word;
                        if (t == 12) tcp_off_byte = b;
                        if (t == 13) tcp_flags = b;
                        if (t < tlen) begin
                            if (t[0]) begin
                                l4_csum = csum_add(l4_csum, word);
                            end else if (t + 1 == tlen) begin
                                // An odd final byte is padded with a zero low byte.
                                l4_csum = csum_add(l4_csum, {b, 8'h00});
                            end
                        end
                    end
                    if (!k[0]) byte_hold = b;
                end
            end
            rx_count++;
        end

        if (last) begin
            r = '0;
            need = 14;
            r.frame_kind = FK_OTHER;
            if (eth_type == ETH_TYPE_IPV4) begin
                start = seg_start();
                tlen = seg_len();
                r.frame_kind = FK_IPV4;
                if (ip_proto == PROTO_ICMP) begin
                    r.transport_kind = TK_ICMP;
                    need = 14 + start + 8;
                end else if (ip_proto == PROTO_TCP) begin
                    r.transport_kind = TK_TCP;
                    need = 14 + start + ((tlen < 20) ? 20 : tlen);
                end else if (ip_proto == PROTO_UDP) begin
                    r.transport_kind = TK_UDP;
                    need = 14 + start + 8;
                end else begin
                    r.transport_kind = TK_OTHER;
                    need = 14 + start;
                end
            end else if (eth_type == ETH_TYPE_ARP) begin
                r.frame_kind = FK_ARP;
                need = 14 + 28;
            end
            r.truncated = rx_count < need;

            if (r.frame_kind == FK_IPV4) begin
                r.ip_version = ip_ver;
                r.ip_header_bytes = ip_hlen;
                r.ip_sum_ok = !r.truncated && ip_csum == 16'hFFFF;
                if (r.transport_kind == TK_TCP || r.transport_kind == TK_UDP) begin
                    r.source_port = sport;
                    r.dest_port = dport;
                end
                if (r.transport_kind == TK_TCP) begin
                    // Close the pseudo-header with the protocol and the TCP length.
                    tcp_total = csum_add(l4_csum, 16'd6);
                    tcp_total = csum_add(tcp_total, seg_len());
                    r.tcp_sum_ok = !r.truncated && tcp_total == 16'hFFFF;
                    r.tcp_flag_bits = tcp_flags;
                    r.tcp_offset_bytes = {tcp_off_byte[7:4], 2'b00};
                end
                // The ICMP type is the first transport byte.
                if (r.transport_kind == TK_ICMP) r.op_code = {8'h00, sport[15:8]};
            end else if (r.frame_kind == FK_ARP) begin
                r.op_code = arp_op;
            end
            summary_q.push_back(r);
            clear_parse_state();
        end
    endtask

    // Ones'-complement sum of frame bytes taken as big-endian words. Bytes past
    // the end of the frame count as zero.
    function automatic logic [15:0] frame_sum(input int from, input int count);
        logic [15:0] acc;
        logic [7:0]  lo;
        int          j;
        acc = '0;
        for (j = 0; j < count && from + j < frm.size(); j += 2) begin
            lo = (j + 1 < count && from + j + 1 < frm.size()) ? frm[from + j + 1] : 8'h00;
            acc = csum_add(acc, {frm[from + j], lo});
        end
        return acc;
    endfunction

    task automatic add_random(input int n);
        repeat (n) frm.push_back(rnd8());
    endtask

    // Random MAC addresses followed by the given EtherType.
    task automatic start_eth(input logic [15:0] etype);
        frm.delete();
        add_random(12);
        frm.push_back(etype[15:8]);
        frm.push_back(etype[7:0]);
    endtask

    task automatic make_arp(input logic [15:0] op, input int pad_n);
        start_eth(ETH_TYPE_ARP);
        add_random(6);
        frm.push_back(op[15:8]);
        frm.push_back(op[7:0]);
        add_random(20 + pad_n);
    endtask

    // Builds an IPv4 frame with valid checksums. A negative total_override keeps
    // the natural total length; corrupt flips one bit after the sums are set.
    task automatic make_ipv4(input logic [7:0] proto, input int ihl, input int ver,
                             input int seg_n, input int total_override, input int pad_n,
                             input bit corrupt);
        int          hlen;
        int          tstart;
        int          tot;
        int          tlen;
        int          idx;
        logic [7:0]  first_byte;
        logic [15:0] s;

        hlen = ihl * 4;
        tstart = (hlen < 20) ? 20 : hlen;
        tot = (total_override < 0) ? tstart + seg_n : total_override;
        first_byte = 8'((ver << 4) | ihl);

        start_eth(ETH_TYPE_IPV4);
        frm.push_back(first_byte);
        frm.push_back(rnd8());
        frm.push_back(tot[15:8]);
        frm.push_back(tot[7:0]);
        add_random(5);
        frm.push_back(proto);
        frm.push_back(8'h00);
        frm.push_back(8'h00);
        add_random(tstart - 12);
        add_random(seg_n + pad_n);

        // The header sum only has a checksum field to fix when IHL reaches it.
        if (hlen >= 12) begin
            s = ~frame_sum(14, hlen);
            frm[24] = s[15:8];
            frm[25] = s[7:0];
        end

        tlen = (tot - tstart) & 16'hFFFF;
        if (proto == PROTO_TCP && tlen >= 18 && seg_n >= 18) begin
            frm[14 + tstart + 16] = 8'h00;
            frm[14 + tstart + 17] = 8'h00;
            s = csum_add(frame_sum(26, 8), 16'd6);
            s = csum_add(s, tlen[15:0]);
            s = ~csum_add(s, frame_sum(14 + tstart, tlen));
            frm[14 + tstart + 16] = s[15:8];
            frm[14 + tstart + 17] = s[7:0];
        end

        if (corrupt) begin
            idx = 14 + $urandom_range(0, frm.size() - 15);
            frm[idx] = frm[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    // Queues the frame for sending, cut short to the given length when that is
    // positive and below the frame size.
    task automatic ship_frame(input int cut);
        int    n;
        int    j;
        beat_t item;
        n = (cut > 0 && cut < frm.size()) ? cut : frm.size();
        for (j = 0; j < n; j++) begin
            item.data = frm[j];
            item.last = (j == n - 1);
            byte_q.push_back(item);
        end
    endtask

    // Mostly well-formed IPv4 traffic with random content, plus ARP, foreign
    // EtherTypes, odd header lengths, bad lengths, bit errors and cut frames.
    task automatic random_frame();
        int         pick;
        int         ihl;
        int         ver;
        int         seg_n;
        int         tot;
        int         pad_n;
        logic [7:0] proto;

        pick = $urandom_range(0, 99);
        pad_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (pick < 10) begin
            start_eth({rnd8(), rnd8()});
            add_random($urandom_range(0, 50));
        end else if (pick < 22) begin
            make_arp(($urandom_range(0, 3) == 0) ? {rnd8(), rnd8()}
                                                  : 16'($urandom_range(1, 4)), pad_n);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                proto = PROTO_TCP;
                seg_n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19)
                                                     : $urandom_range(20, 48);
            end else if (pick < 65) begin
                proto = PROTO_UDP;
                seg_n = $urandom_range(8, 24);
            end else if (pick < 80) begin
                proto = PROTO_ICMP;
                seg_n = $urandom_range(8, 24);
            end else begin
                proto = rnd8();
                seg_n = $urandom_range(0, 24);
            end
            ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
            ver = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 4;
            tot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : -1;
            make_ipv4(proto, ihl, ver, seg_n, tot, pad_n, $urandom_range(0, 9) == 0);
        end
        ship_frame(($urandom_range(0, 6) == 0) ? $urandom_range(1, frm.size()) : 0);
    endtask

    task automatic draw_gap(inout bit busy, output int gap);
        if ($urandom_range(0, 39) == 0) busy = !busy;
        gap = busy ? $urandom_range(0, 16) : 0;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Input side. The accepted byte is fed to the tracker at the handshake edge,
    // then the next byte is presented once its idle gap has run out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    beat = byte_q.pop_front();
                    s_axis_tdata <= beat.data;
                    s_axis_tlast <= beat.last;
                    s_axis_tvalid <= 1'b1;
                    draw_gap(src_busy, src_gap);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side. Every summary transaction is checked field by field against
    // the oldest expected one; tready may then drop for a random idle gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata;
                if (summary_q.size() == 0) begin
                    $error("unexpected summary transaction %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = summary_q.pop_front();
                    check_field("frame_kind", want.frame_kind, seen.frame_kind);
                    check_field("transport_kind", want.transport_kind, seen.transport_kind);
                    check_field("ip_version", want.ip_version, seen.ip_version);
                    check_field("ip_header_bytes", want.ip_header_bytes, seen.ip_header_bytes);
                    check_field("ip_sum_ok", want.ip_sum_ok, seen.ip_sum_ok);
                    check_field("tcp_sum_ok", want.tcp_sum_ok, seen.tcp_sum_ok);
                    check_field("source_port", want.source_port, seen.source_port);
                    check_field("dest_port", want.dest_port, seen.dest_port);
                    check_field("tcp_flag_bits", want.tcp_flag_bits, seen.tcp_flag_bits);
                    check_field("tcp_offset_bytes", want.tcp_offset_bytes,
                                seen.tcp_offset_bytes);
                    check_field("op_code", want.op_code, seen.op_code);
                    check_field("truncated", want.truncated, seen.truncated);
                end
                draw_gap(sink_busy, sink_gap);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog against a hung handshake or a summary that never arrives.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("packet_header_parser_test: done, errors");
            $finish;
        end
    end

    initial begin
        clear_parse_state();

        // Runt frames: a single byte, and one that stops inside the EtherType,
        // which must read as a foreign EtherType.
        start_eth(ETH_TYPE_IPV4);
        ship_frame(1);
        start_eth(ETH_TYPE_IPV4);
        ship_frame(13);
        // Foreign EtherTypes at both ends of the range, bare header and padded.
        start_eth(16'hFFFF);
        ship_frame(0);
        start_eth(16'h0000);
        add_random(50);
        ship_frame(0);
        // ARP: request, largest opcode with padding, and a body cut short.
        make_arp(16'h0001, 0);
        ship_frame(0);
        make_arp(16'hFFFF, 18);
        ship_frame(0);
        make_arp(16'h0002, 0);
        ship_frame(20);
        // Plain ICMP, UDP and TCP.
        make_ipv4(PROTO_ICMP, 5, 4, 8, -1, 0, 0);
        ship_frame(0);
        make_ipv4(PROTO_UDP, 5, 4, 16, -1, 6, 0);
        ship_frame(0);
        make_ipv4(PROTO_TCP, 5, 4, 20, -1, 0, 0);
        ship_frame(0);
        // Largest IP header with an odd-length TCP segment.
        make_ipv4(PROTO_TCP, 15, 4, 41, -1, 0, 0);
        ship_frame(0);
        // A flipped bit must break one of the two sums.
        make_ipv4(PROTO_TCP, 5, 4, 32, -1, 0, 1);
        ship_frame(0);
        // TCP segment cut in the middle.
        make_ipv4(PROTO_TCP, 5, 4, 40, -1, 0, 0);
        ship_frame(50);
        // ICMP one byte short of its header.
        make_ipv4(PROTO_ICMP, 5, 4, 8, -1, 0, 0);
        ship_frame(14 + 20 + 7);
        // Unknown protocol with the top version nibble.
        make_ipv4(8'hFF, 5, 15, 4, -1, 0, 0);
        ship_frame(0);
        // IHL below five: zero, and three where the checksum field is still covered.
        make_ipv4(PROTO_TCP, 0, 4, 24, -1, 0, 0);
        ship_frame(0);
        make_ipv4(PROTO_UDP, 3, 4, 8, -1, 0, 0);
        ship_frame(0);
        // Total length below the header size, so the TCP length wraps.
        make_ipv4(PROTO_TCP, 5, 4, 24, 10, 0, 0);
        ship_frame(0);
        // TCP length under 20: the frame must still carry a full 20-byte header.
        make_ipv4(PROTO_TCP, 5, 4, 8, -1, 12, 0);
        ship_frame(0);

        // Random frames fill the run up to about 1550 bytes.
        while (byte_q.size() < 1550) begin
            random_frame();
        end
        total_bytes = byte_q.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken < total_bytes) @(posedge aclk);
        while (summary_q.size() > 0) @(posedge aclk);
        // Let a stray summary show up before the verdict.
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("packet_header_parser_test: done, clean");
        end else begin
            $display("packet_header_parser_test: done, errors");
        end
        $finish;
    end

endmodule

/* packet_header_parser.f */
+incdir+rtl
rtl/php_pkg.sv
rtl/php_parse.sv
rtl/php_summary.sv
rtl/packet_header_parser.sv
test/packet_header_parser_test.sv
